>>> design/velocity_frame_rotation_unit_macros.svh
// assertion macros used by the velocity frame rotation unit
`ifndef VELOCITY_FRAME_ROTATION_UNIT_MACROS_SVH
`define VELOCITY_FRAME_ROTATION_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define VFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfr check failed in the same cycle");

// antecedent in this cycle implies consequent in the next cycle
`define VFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfr check failed one cycle later");

`endif

>>> design/vfr_pkg.sv
// constants, types and the arctangent table of the velocity frame rotation unit
`default_nettype none
package vfr_pkg;

  // field widths
  localparam int VEL_WIDTH     = 16;
  localparam int YAW_WIDTH     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  // gain compensation, round(0.60725293500888 * 2^24)
  localparam int KGAIN_W    = 24;
  localparam int WORK_SHIFT = 24;
  localparam logic signed [KGAIN_W:0] KGAIN = 25'sd10188014;

  // working widths: operand, gain and headroom for the vector growth
  localparam int XY_W    = VEL_WIDTH + KGAIN_W + 2;
  localparam int Z_W     = 33;
  localparam int SHIFT_W = $clog2(ATAN_ENTRIES);

  // stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((2 * VEL_WIDTH + YAW_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * VEL_WIDTH + 7) / 8) * 8;

  // atan(2^-i) scaled so that 2^31 is pi
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // vector and residual angle handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

endpackage
`default_nettype wire

>>> design/velocity_frame_rotation_unit.sv
// Velocity frame rotation: rotates a planar velocity (vel_x, vel_y), signed Q5.10, by
// +yaw (16-bit binary angle, 32768 is pi) with a gain-compensated CORDIC and returns
// (rot_x, rot_y) rounded and saturated to Q5.10. The datapath is a row of pipeline
// stages: one entry stage (quadrant fold and gain multiply), one cell per micro-rotation
// (16 cells), and a rounding/output register, 18 registers in all; in steady state one
// transfer per cycle is taken while the output is not stalled. Every stage has its
// own valid bit and takes new data whenever it is empty or its successor takes its
// contents, so a stall on the output only fills the bubbles behind it.
`default_nettype none
`include "velocity_frame_rotation_unit_macros.svh"
module velocity_frame_rotation_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // vel_x [15:0], vel_y [31:16], yaw [47:32]
  input  wire logic [vfr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // rot_x [15:0], rot_y [31:16]
  output      logic [vfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int VW = vfr_pkg::VEL_WIDTH;
  localparam int NS = vfr_pkg::NUM_STAGES;

  logic signed [VW-1:0]                 vel_x, vel_y, rot_x, rot_y;
  logic signed [vfr_pkg::YAW_WIDTH-1:0] yaw;
  logic                                 chain_valid [NS+1];
  logic                                 chain_ready [NS+1];
  vfr_pkg::vec_t                        chain_data  [NS+1];

  // unpack the input transfer
  assign vel_x = s_axis_tdata[VW-1:0];
  assign vel_y = s_axis_tdata[2*VW-1:VW];
  assign yaw   = s_axis_tdata[2*VW+vfr_pkg::YAW_WIDTH-1:2*VW];

  // entry stage
  vfr_prescale u_prescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .vel_x_i (vel_x),
    .vel_y_i (vel_y),
    .yaw_i   (yaw),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // micro-rotation cells
  for (genvar k = 0; k < NS; k++) begin : g_cell
    vfr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (vfr_pkg::SHIFT_W'(k)),
      .atan_i  (vfr_pkg::Z_W'(vfr_pkg::ATAN_TAB[k])),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // rounding and output register
  vfr_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NS]),
    .ready_o (chain_ready[NS]),
    .data_i  (chain_data[NS]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rot_x_o (rot_x),
    .rot_y_o (rot_y)
  );

  // pack the result transfer, zero padding above
  assign m_axis_tdata = vfr_pkg::OUT_TDATA_W'({rot_y, rot_x});

  // an empty entry stage always takes a transfer
  `VFR_ASSERT_SAME(a_entry_ready, clk_i, rst_ni, !chain_valid[0], s_axis_tready)
  // an accepted transfer occupies the entry stage next cycle
  `VFR_ASSERT_NEXT(a_entry_fill, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, chain_valid[0])
  // a handover from the last cell lands in the output register
  `VFR_ASSERT_NEXT(a_out_fill, clk_i, rst_ni, chain_valid[NS] && chain_ready[NS], m_axis_tvalid)

endmodule
`default_nettype wire

>>> design/vfr_prescale.sv
// entry stage: quadrant fold of the angle and gain-compensating multiply
`default_nettype none
module vfr_prescale (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    valid_i,
  output      logic                                    ready_o,
  input  wire logic signed [vfr_pkg::VEL_WIDTH-1:0]    vel_x_i,
  input  wire logic signed [vfr_pkg::VEL_WIDTH-1:0]    vel_y_i,
  input  wire logic signed [vfr_pkg::YAW_WIDTH-1:0]    yaw_i,
  output      logic                                    valid_o,
  input  wire logic                                    ready_i,
  output      vfr_pkg::vec_t                           data_o
);

  localparam logic signed [vfr_pkg::YAW_WIDTH-1:0] YAW_QUARTER =
    vfr_pkg::YAW_WIDTH'(1 << (vfr_pkg::YAW_WIDTH - 2));
  localparam logic signed [vfr_pkg::Z_W-1:0] Z_QUARTER = vfr_pkg::Z_W'(1 << 30);

  logic signed [vfr_pkg::VEL_WIDTH:0] vx_ext, vy_ext, x_sel, y_sel;
  logic signed [vfr_pkg::Z_W-1:0]     z_raw, z_sel;
  vfr_pkg::vec_t                      data_d, data_q;
  logic                               valid_q;

  // fold the angle into [-pi/2, pi/2] by a quarter turn of the raw vector
  always_comb begin
    vx_ext = {vel_x_i[vfr_pkg::VEL_WIDTH-1], vel_x_i};
    vy_ext = {vel_y_i[vfr_pkg::VEL_WIDTH-1], vel_y_i};
    z_raw  = {yaw_i[vfr_pkg::YAW_WIDTH-1], yaw_i, 16'd0};
    if (yaw_i > YAW_QUARTER) begin
      x_sel = -vy_ext;
      y_sel = vx_ext;
      z_sel = z_raw - Z_QUARTER;
    end else if (yaw_i < -YAW_QUARTER) begin
      x_sel = vy_ext;
      y_sel = -vx_ext;
      z_sel = z_raw + Z_QUARTER;
    end else begin
      x_sel = vx_ext;
      y_sel = vy_ext;
      z_sel = z_raw;
    end
    data_d.x = x_sel * vfr_pkg::KGAIN;
    data_d.y = y_sel * vfr_pkg::KGAIN;
    data_d.z = z_sel;
  end

  assign ready_o = !valid_q || ready_i;

  // stage handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> design/vfr_cell.sv
// one cordic micro-rotation with its own pipeline register
`default_nettype none
module vfr_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [vfr_pkg::SHIFT_W-1:0]         shift_i,
  input  wire logic signed [vfr_pkg::Z_W-1:0]      atan_i,
  input  wire logic                                valid_i,
  output      logic                                ready_o,
  input  wire vfr_pkg::vec_t                       data_i,
  output      logic                                valid_o,
  input  wire logic                                ready_i,
  output      vfr_pkg::vec_t                       data_o
);

  logic signed [vfr_pkg::XY_W-1:0] dx, dy;
  vfr_pkg::vec_t                   data_d, data_q;
  logic                            valid_q;

  // rotate towards zero residual angle
  always_comb begin
    dx = data_i.y >>> shift_i;
    dy = data_i.x >>> shift_i;
    if (!data_i.z[vfr_pkg::Z_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - atan_i;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + atan_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> design/vfr_finish.sv
// rounding, saturation and the output register
`default_nettype none
module vfr_finish (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  output      logic                                   ready_o,
  input  wire vfr_pkg::vec_t                          data_i,
  output      logic                                   valid_o,
  input  wire logic                                   ready_i,
  output      logic signed [vfr_pkg::VEL_WIDTH-1:0]   rot_x_o,
  output      logic signed [vfr_pkg::VEL_WIDTH-1:0]   rot_y_o
);

  localparam int SUM_W = vfr_pkg::XY_W + 1;
  localparam int RND_W = SUM_W - vfr_pkg::WORK_SHIFT;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (vfr_pkg::WORK_SHIFT - 1);
  localparam logic signed [RND_W-1:0] HI =
    RND_W'((64'sd1 <<< (vfr_pkg::VEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] LO = -HI - RND_W'(1);

  logic signed [SUM_W-1:0]             sum_x, sum_y;
  logic signed [RND_W-1:0]             rnd_x, rnd_y;
  logic signed [vfr_pkg::VEL_WIDTH-1:0] sat_x, sat_y, rot_x_q, rot_y_q;
  logic                                valid_q;

  // round to nearest and clamp to the field range
  always_comb begin
    sum_x = {data_i.x[vfr_pkg::XY_W-1], data_i.x} + HALF;
    sum_y = {data_i.y[vfr_pkg::XY_W-1], data_i.y} + HALF;
    rnd_x = RND_W'(sum_x >>> vfr_pkg::WORK_SHIFT);
    rnd_y = RND_W'(sum_y >>> vfr_pkg::WORK_SHIFT);
    priority if (rnd_x > HI) begin
      sat_x = vfr_pkg::VEL_WIDTH'(HI);
    end else if (rnd_x < LO) begin
      sat_x = vfr_pkg::VEL_WIDTH'(LO);
    end else begin
      sat_x = vfr_pkg::VEL_WIDTH'(rnd_x);
    end
    priority if (rnd_y > HI) begin
      sat_y = vfr_pkg::VEL_WIDTH'(HI);
    end else if (rnd_y < LO) begin
      sat_y = vfr_pkg::VEL_WIDTH'(LO);
    end else begin
      sat_y = vfr_pkg::VEL_WIDTH'(rnd_y);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rot_x_q <= sat_x;
      rot_y_q <= sat_y;
    end
  end

  assign valid_o = valid_q;
  assign rot_x_o = rot_x_q;
  assign rot_y_o = rot_y_q;

endmodule
`default_nettype wire
